// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the seed/key access controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication property on the rising clock edge, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  `ASSERT_CLK(label, clk, rst, (1'b1 |-> (cond)), msg)

`endif

// ----- rtl/skac_pkg.sv -----
// Package with the types and constants of the seed/key access controller.
package skac_pkg;

  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE       = 8'h01;
  localparam logic [KEY_W-1:0]   ZERO_SEED_SUBST = 32'hA5A5_A5A5;
  localparam logic [TIME_W-1:0]  TIME_MAX        = {TIME_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};

  localparam logic [COUNT_W-1:0]    MAX_FAILURES_RST = 8'd3;
  localparam logic [KEY_W-1:0]      LOCKOUT_DUR_RST  = 32'd10000;
  localparam logic [KEY_W-1:0]      KEY_MASK_RST     = 32'hDEAD_BEEF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_FAILURES = 2'd0,
    CFG_LOCKOUT_DUR  = 2'd1,
    CFG_KEY_MASK     = 2'd2
  } cfg_index_t;

  typedef enum logic {
    OP_SEED_REQ = 1'b0,
    OP_SEND_KEY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    OUT_ISSUED   = 2'd0,
    OUT_UNLOCKED = 2'd1,
    OUT_ACCEPTED = 2'd2,
    OUT_REFUSED  = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LEVEL    = 3'd1,
    ERR_SEQUENCE = 3'd2,
    ERR_DELAY    = 3'd3,
    ERR_INVALID  = 3'd4,
    ERR_EXCEEDED = 3'd5
  } error_t;

  // One request as held in the input stage.
  typedef struct packed {
    op_t                op;
    logic [LEVEL_W-1:0] access_level;
    logic [KEY_W-1:0]   key_value;
    logic [KEY_W-1:0]   entropy;
    logic [TIME_W-1:0]  now_ms;
  } req_t;

  // One reply as held in the output register.
  typedef struct packed {
    logic           level_unlocked;
    logic [KEY_W-1:0] seed;
    error_t         error_code;
    outcome_t       outcome;
  } rsp_t;

endpackage

// ----- rtl/seed_key_access_control_top.sv -----
// Top level of the seed/key security-access controller.

// Seed/key access controller for security level 1. Each input word is a seed request
// (tuser 0) or a key submission (tuser 1), and each one yields exactly one output word.
// A word passes through an input register and then an output register, which offers its
// reply on the output stream once the decision stage has written it there, and a new
// word is taken every cycle as long as the output side keeps up. All decision logic
// sits in the one stage between these registers: the 48-bit lockout compare, the
// saturating 48-bit lockout end sum and the key XOR compare set the clock period. The
// lockout, failure count, pending seed and unlocked level are updated as each word
// leaves the input register, so back-to-back words always see the state left by the
// word before them. Configuration writes take effect at the next clock edge and are
// meant to be made while no word is in flight.
module seed_key_access_control_top (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [skac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skac_pkg::CFG_DATA_W-1:0] cfg_data,
  // Request stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0 up: access_level[7:0], key_value[39:8], entropy[71:40],
  // now_ms[119:72].
  input  logic [skac_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0 up: op[0].
  input  logic                            s_axis_tuser,
  // Reply stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0 up: outcome[1:0], error_code[4:2], seed[36:5],
  // level_unlocked[37], zero padding[39:38].
  output logic [skac_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import skac_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers.
  logic [COUNT_W-1:0] max_failures;
  logic [KEY_W-1:0]   lockout_duration_ms;
  logic [KEY_W-1:0]   key_mask;

  // Access state.
  logic               unlocked;
  logic               seed_pending;
  logic [KEY_W-1:0]   issued_seed;
  logic [COUNT_W-1:0] failure_count;
  logic [TIME_W-1:0]  lockout_end_ms;

  logic               unlocked_next;
  logic               seed_pending_next;
  logic [KEY_W-1:0]   issued_seed_next;
  logic [COUNT_W-1:0] failure_count_next;
  logic [TIME_W-1:0]  lockout_end_ms_next;

  // Input stage and output register.
  logic  req_valid;
  req_t  req;
  logic  rsp_valid;
  rsp_t  rsp;
  rsp_t  rsp_next;

  logic               advance;
  logic               lockout_active;
  logic [TIME_W:0]    end_sum;
  logic [TIME_W-1:0]  end_sat;
  logic [COUNT_W-1:0] count_inc;
  logic [KEY_W-1:0]   new_seed;

  // The output register frees up when empty or when its word is taken.
  assign advance       = !rsp_valid || m_axis_tready;
  assign s_axis_tready = !req_valid || advance;
  assign m_axis_tvalid = rsp_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - $bits(rsp_t)){1'b0}}, rsp};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_failures        <= MAX_FAILURES_RST;
      lockout_duration_ms <= LOCKOUT_DUR_RST;
      key_mask            <= KEY_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_FAILURES: max_failures        <= cfg_data[COUNT_W-1:0];
        CFG_LOCKOUT_DUR:  lockout_duration_ms <= cfg_data[KEY_W-1:0];
        CFG_KEY_MASK:     key_mask            <= cfg_data[KEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage: holds one request until the decision stage can take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_axis_tready) begin
      req_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      req.op           <= op_t'(s_axis_tuser);
      req.access_level <= s_axis_tdata[7:0];
      req.key_value    <= s_axis_tdata[39:8];
      req.entropy      <= s_axis_tdata[71:40];
      req.now_ms       <= s_axis_tdata[119:72];
    end
  end

  // Lockout end time, saturated at the top of the time range.
  assign end_sum = {1'b0, req.now_ms} + {{(TIME_W + 1 - KEY_W){1'b0}}, lockout_duration_ms};
  assign end_sat = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];

  assign lockout_active = (lockout_end_ms != '0) && (req.now_ms < lockout_end_ms);
  assign count_inc      = (failure_count == COUNT_MAX) ? failure_count : failure_count + 1'b1;
  assign new_seed       = (req.entropy == '0) ? ZERO_SEED_SUBST : req.entropy;

  always_comb begin
    unlocked_next       = unlocked;
    seed_pending_next   = seed_pending;
    issued_seed_next    = issued_seed;
    failure_count_next  = failure_count;
    lockout_end_ms_next = lockout_end_ms;
    rsp_next.outcome    = OUT_REFUSED;
    rsp_next.error_code = ERR_NONE;
    rsp_next.seed       = '0;

    if (req.access_level != LEVEL_ONE) begin
      rsp_next.error_code = ERR_LEVEL;
    end else if (req.op == OP_SEED_REQ) begin
      if (unlocked) begin
        seed_pending_next = 1'b0;
        rsp_next.outcome  = OUT_UNLOCKED;
      end else if (lockout_active) begin
        rsp_next.error_code = ERR_DELAY;
      end else begin
        // An expired lockout is forgotten together with the failure history.
        if (lockout_end_ms != '0) begin
          lockout_end_ms_next = '0;
          failure_count_next  = '0;
        end
        issued_seed_next  = new_seed;
        seed_pending_next = 1'b1;
        rsp_next.outcome  = OUT_ISSUED;
        rsp_next.seed     = new_seed;
      end
    end else if (!seed_pending) begin
      rsp_next.error_code = ERR_SEQUENCE;
    end else if (lockout_active) begin
      rsp_next.error_code = ERR_DELAY;
    end else begin
      // The seed is used up by this attempt, right or wrong.
      seed_pending_next = 1'b0;
      if (req.key_value == (issued_seed ^ key_mask)) begin
        unlocked_next      = 1'b1;
        failure_count_next = '0;
        rsp_next.outcome   = OUT_ACCEPTED;
      end else begin
        failure_count_next = count_inc;
        if (count_inc >= max_failures) begin
          lockout_end_ms_next = end_sat;
          rsp_next.error_code = ERR_EXCEEDED;
        end else begin
          rsp_next.error_code = ERR_INVALID;
        end
      end
    end

    // Level 0 is always covered; levels above one never are.
    rsp_next.level_unlocked = (req.access_level == '0) ||
                              ((req.access_level == LEVEL_ONE) && unlocked_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unlocked       <= 1'b0;
      seed_pending   <= 1'b0;
      issued_seed    <= '0;
      failure_count  <= '0;
      lockout_end_ms <= '0;
      rsp_valid      <= 1'b0;
    end else if (advance) begin
      rsp_valid <= req_valid;
      if (req_valid) begin
        unlocked       <= unlocked_next;
        seed_pending   <= seed_pending_next;
        issued_seed    <= issued_seed_next;
        failure_count  <= failure_count_next;
        lockout_end_ms <= lockout_end_ms_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && req_valid) begin
      rsp <= rsp_next;
    end
  end

  // An issued seed is never zero.
  `ASSERT_CLK(a_seed_nonzero, clk, rst, (rsp_valid && rsp.outcome == OUT_ISSUED) |-> (rsp.seed != '0), "issued seed is zero")

  // Once unlocked, no seed stays pending.
  `ASSERT_ALWAYS(a_unlocked_no_pending, clk, rst, (!unlocked || !seed_pending), "seed pending while unlocked")

  // Refusals carry an error code and every other reply carries none.
  `ASSERT_CLK(a_refusal_error, clk, rst, rsp_valid |-> ((rsp.outcome == OUT_REFUSED) == (rsp.error_code != ERR_NONE)), "outcome and error code disagree")

endmodule

// ----- tb/seed_key_access_control_top_tb.sv -----
// Self-checking testbench for the seed/key security-access controller.
import skac_pkg::*;

// Predicts the reply to every accepted request word and checks the reply words in order.
class access_predictor;
  logic [COUNT_W-1:0] max_failures;
  logic [KEY_W-1:0]   lockout_ms;
  logic [KEY_W-1:0]   key_mask;
  logic [LEVEL_W-1:0] granted_level;
  logic               seed_pending;
  logic [KEY_W-1:0]   issued_seed;
  logic [COUNT_W-1:0] failure_count;
  logic [TIME_W-1:0]  lockout_end;
  rsp_t               expected_replies[$];
  int unsigned        errors;
  int unsigned        replies_checked;
  int unsigned        seeds_issued;
  int unsigned        lockouts_started;
  int unsigned        keys_accepted;
  int unsigned        peak_failures;

  function new();
    max_failures   = MAX_FAILURES_RST;
    lockout_ms     = LOCKOUT_DUR_RST;
    key_mask       = KEY_MASK_RST;
    granted_level  = '0;
    seed_pending   = 1'b0;
    issued_seed    = '0;
    failure_count  = '0;
    lockout_end    = '0;
  endfunction

  function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_MAX_FAILURES: max_failures = value[COUNT_W-1:0];
      CFG_LOCKOUT_DUR:  lockout_ms = value;
      CFG_KEY_MASK:     key_mask = value;
      default: ;
    endcase
  endfunction

  // Applies one request to the tracked state and queues the reply it must produce.
  function void note_request(req_t req);
    rsp_t            rsp;
    logic [TIME_W:0] lock_sum;
    rsp.outcome = OUT_REFUSED;
    rsp.error_code = ERR_NONE;
    rsp.seed = '0;
    if (req.access_level != LEVEL_ONE) begin
      rsp.error_code = ERR_LEVEL;
    end else if (req.op == OP_SEED_REQ) begin
      if (granted_level >= req.access_level) begin
        seed_pending = 1'b0;
        rsp.outcome = OUT_UNLOCKED;
      end else if (lockout_end != '0 && req.now_ms < lockout_end) begin
        rsp.error_code = ERR_DELAY;
      end else begin
        // An expired lockout is forgotten along with the failures that caused it.
        if (lockout_end != '0) begin
          lockout_end = '0;
          failure_count = '0;
        end
        issued_seed = (req.entropy == '0) ? ZERO_SEED_SUBST : req.entropy;
        seed_pending = 1'b1;
        rsp.outcome = OUT_ISSUED;
        rsp.seed = issued_seed;
        seeds_issued++;
      end
    end else if (!seed_pending) begin
      rsp.error_code = ERR_SEQUENCE;
    end else if (lockout_end != '0 && req.now_ms < lockout_end) begin
      rsp.error_code = ERR_DELAY;
    end else begin
      seed_pending = 1'b0;
      if (req.key_value == (issued_seed ^ key_mask)) begin
        granted_level = LEVEL_ONE;
        failure_count = '0;
        rsp.outcome = OUT_ACCEPTED;
        keys_accepted++;
      end else begin
        if (failure_count != COUNT_MAX) failure_count++;
        if (failure_count > peak_failures) peak_failures = 32'(failure_count);
        if (failure_count >= max_failures) begin
          lock_sum = {1'b0, req.now_ms} + {{(TIME_W + 1 - KEY_W){1'b0}}, lockout_ms};
          lockout_end = lock_sum[TIME_W] ? TIME_MAX : lock_sum[TIME_W-1:0];
          rsp.error_code = ERR_EXCEEDED;
          lockouts_started++;
        end else begin
          rsp.error_code = ERR_INVALID;
        end
      end
    end
    rsp.level_unlocked = (granted_level >= req.access_level);
    expected_replies.push_back(rsp);
  endfunction

  function void check_reply(logic [OUT_DATA_W-1:0] data);
    rsp_t got;
    rsp_t want;
    got = rsp_t'(data[$bits(rsp_t)-1:0]);
    if (expected_replies.size() == 0) begin
      $error("reply word 0x%h arrived with no request outstanding", data);
      errors++;
      return;
    end
    want = expected_replies.pop_front();
    replies_checked++;
    if (got.outcome !== want.outcome) begin
      $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
      errors++;
    end
    if (got.error_code !== want.error_code) begin
      $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
      errors++;
    end
    if (got.seed !== want.seed) begin
      $error("seed: expected 0x%h, got 0x%h", want.seed, got.seed);
      errors++;
    end
    if (got.level_unlocked !== want.level_unlocked) begin
      $error("level_unlocked: expected %0d, got %0d", want.level_unlocked, got.level_unlocked);
      errors++;
    end
  endfunction
endclass

module seed_key_access_control_top_tb;

  // Idle patterns applied phase by phase on the request and reply streams.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // About 1800 words; even with both sides idling and a handful of drains in the run,
  // this limit is many times the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
  logic                    s_axis_tuser = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;

  access_predictor   book = new();
  idle_mode_t        idle_mode = IDLE_NONE;
  logic [TIME_W-1:0] clock_ms = '0;
  int unsigned       cycle_count = 0;
  int unsigned       settings_used = 0;

  seed_key_access_control_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // The watchdog ends a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The reply side samples the previous cycle's handshake at each rising edge and then
  // decides whether it stalls during the coming cycle.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) book.check_reply(m_axis_tdata);
    case (idle_mode)
      IDLE_RECEIVER: m_axis_tready <= ($urandom_range(0, 99) >= 45);
      IDLE_BOTH:     m_axis_tready <= ($urandom_range(0, 99) >= 12);
      default:       m_axis_tready <= 1'b1;
    endcase
  end

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 45;
      IDLE_BOTH:   return $urandom_range(0, 99) < 12;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] later(logic [TIME_W-1:0] t, logic [TIME_W-1:0] d);
    logic [TIME_W:0] sum;
    sum = {1'b0, t} + {1'b0, d};
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] right_key();
    return book.issued_seed ^ book.key_mask;
  endfunction

  // A wrong key is either one bit away from the right one or a random word.
  function automatic logic [KEY_W-1:0] wrong_key();
    logic [KEY_W-1:0] good;
    logic [KEY_W-1:0] bad;
    good = right_key();
    if ($urandom_range(0, 1) == 0) return good ^ (32'h1 << $urandom_range(0, 31));
    bad = $urandom;
    if (bad == good) bad = ~good;
    return bad;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_entropy();
    return ($urandom_range(0, 15) == 0) ? '0 : $urandom;
  endfunction

  // Offers one request word, with random gaps before it, and waits until it is taken.
  task automatic send_request(op_t op, logic [LEVEL_W-1:0] level, logic [KEY_W-1:0] key,
                              logic [KEY_W-1:0] entropy, logic [TIME_W-1:0] now);
    req_t req;
    req.op = op;
    req.access_level = level;
    req.key_value = key;
    req.entropy = entropy;
    req.now_ms = now;
    while (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {now, entropy, key, level};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    book.note_request(req);
  endtask

  task automatic send_seed(logic [KEY_W-1:0] entropy, logic [TIME_W-1:0] now);
    send_request(OP_SEED_REQ, LEVEL_ONE, $urandom, entropy, now);
  endtask

  task automatic send_key(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
    send_request(OP_SEND_KEY, LEVEL_ONE, key, $urandom, now);
  endtask

  // Any level but one, any operation, all fields random.
  task automatic send_noise();
    logic [LEVEL_W-1:0] level;
    level = LEVEL_W'($urandom_range(0, 255));
    if (level == LEVEL_ONE) level = 8'hFF;
    send_request(op_t'($urandom_range(0, 1)), level, $urandom, $urandom,
                 TIME_W'({$urandom, $urandom}));
  endtask

  // Holds the request side idle until every outstanding reply has been checked.
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (book.expected_replies.size() != 0);
  endtask

  // Writes all three registers back to back once the block has gone quiet.
  task automatic apply_settings(logic [COUNT_W-1:0] failures, logic [KEY_W-1:0] duration,
                                logic [KEY_W-1:0] mask);
    drain_replies();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_FAILURES;
    cfg_data <= {{(CFG_DATA_W-COUNT_W){1'b0}}, failures};
    @(posedge clk);
    book.set_reg(CFG_MAX_FAILURES, {{(CFG_DATA_W-COUNT_W){1'b0}}, failures});
    cfg_index <= CFG_LOCKOUT_DUR;
    cfg_data <= duration;
    @(posedge clk);
    book.set_reg(CFG_LOCKOUT_DUR, duration);
    cfg_index <= CFG_KEY_MASK;
    cfg_data <= mask;
    @(posedge clk);
    book.set_reg(CFG_KEY_MASK, mask);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Moves the tester's clock on. While a lockout runs, the clock usually lands right
  // around its end so that both sides of the boundary are seen.
  task automatic advance_clock();
    if (book.lockout_end != '0 && clock_ms < book.lockout_end &&
        $urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 2))
        0:       clock_ms = book.lockout_end - TIME_W'(1);
        1:       clock_ms = book.lockout_end;
        default: clock_ms = later(book.lockout_end, TIME_W'($urandom_range(0, 500)));
      endcase
    end else begin
      case ($urandom_range(0, 199))
        0:          clock_ms = TIME_MAX - TIME_W'($urandom_range(0, 20000));
        1:          clock_ms = TIME_W'($urandom_range(0, 1000));
        2, 3, 4, 5: clock_ms = later(clock_ms, TIME_W'($urandom));
        default:    clock_ms = later(clock_ms, TIME_W'($urandom_range(0, 3000)));
      endcase
    end
  endtask

  // Random traffic that never presents the right key, so the block stays locked.
  // Most of it is seed/key exchanges; the rest is stray seeds, stray keys and words
  // for unsupported levels. With a frozen clock the time stays at zero and only
  // exchanges are sent, which lets the failure count climb to its ceiling.
  task automatic run_locked_phase(int unsigned words, bit frozen);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < words) begin
      if (!frozen) advance_clock();
      pick = frozen ? 0 : $urandom_range(0, 99);
      if (pick < 55) begin
        send_seed(fresh_entropy(), clock_ms);
        send_key(wrong_key(), clock_ms);
        sent += 2;
      end else if (pick < 70) begin
        send_seed(fresh_entropy(), clock_ms);
        sent++;
      end else if (pick < 85) begin
        send_key(book.seed_pending ? wrong_key() : $urandom, clock_ms);
        sent++;
      end else begin
        send_noise();
        sent++;
      end
      if ($urandom_range(0, 149) == 0) drain_replies();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset register values: a key with no seed, unsupported
    // levels at the field extremes, the zero-entropy seed, a used seed offered twice,
    // and enough wrong keys to start a lockout that is then probed on both sides of
    // its end.
    send_key(32'h0, 48'd0);
    send_request(OP_SEED_REQ, 8'h00, '1, '1, TIME_MAX);
    send_request(OP_SEND_KEY, 8'hFF, '1, '1, TIME_MAX);
    send_request(OP_SEED_REQ, 8'h02, '0, '0, '0);
    send_seed(32'h0, 48'd0);
    send_key(wrong_key(), 48'd0);
    send_key(right_key(), 48'd0);
    send_seed(32'hFFFF_FFFF, 48'd10);
    send_key(wrong_key(), 48'd10);
    send_seed(32'h1234_5678, 48'd100);
    send_key(wrong_key(), 48'd100);
    send_seed(32'h5555_AAAA, 48'd10099);
    send_key(32'hFFFF_FFFF, 48'd10099);
    send_seed(32'h0, 48'd10100);
    send_key(wrong_key(), 48'd10100);

    // A zero failure limit locks out on every wrong key; with a zero duration at time
    // zero the lockout end sums to zero, so no lockout is recorded at all.
    apply_settings(8'd0, 32'd0, 32'd0);
    send_seed(32'hCAFE_0001, 48'd0);
    send_key(wrong_key(), 48'd0);
    send_seed(32'hCAFE_0002, 48'd0);
    send_key(wrong_key(), 48'd7);
    send_seed(32'hCAFE_0003, 48'd7);

    // The longest lockout near the top of the time range saturates its end.
    apply_settings(8'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_key(wrong_key(), TIME_MAX - 5);
    send_seed(32'h8000_0000, TIME_MAX - 1);
    send_seed(32'h0000_0001, TIME_MAX);

    // Random phases, each under its own register setting and idle pattern.
    idle_mode = IDLE_NONE;
    apply_settings(8'd3, 32'd10000, $urandom);
    clock_ms = TIME_W'($urandom_range(0, 1000));
    run_locked_phase(300, 1'b0);

    idle_mode = IDLE_SENDER;
    apply_settings(8'd1, 32'd50, 32'h0);
    clock_ms = TIME_W'($urandom_range(0, 1000));
    run_locked_phase(300, 1'b0);

    idle_mode = IDLE_RECEIVER;
    apply_settings(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    clock_ms = TIME_W'($urandom_range(0, 1000));
    run_locked_phase(250, 1'b0);

    idle_mode = IDLE_BOTH;
    apply_settings(COUNT_W'($urandom_range(2, 8)), $urandom_range(0, 20000), $urandom);
    clock_ms = TIME_W'($urandom_range(0, 1000));
    run_locked_phase(300, 1'b0);

    idle_mode = IDLE_SENDER;
    apply_settings(COUNT_W'($urandom_range(1, 4)), 32'd0, $urandom);
    clock_ms = '0;
    run_locked_phase(560, 1'b1);

    // The right key finally unlocks the block; from then on seed requests are answered
    // as already unlocked and keys find no seed pending.
    idle_mode = IDLE_RECEIVER;
    apply_settings(COUNT_W'($urandom_range(1, 255)), $urandom, $urandom);
    clock_ms = later(clock_ms, TIME_W'(1));
    if (book.lockout_end != '0 && clock_ms < book.lockout_end) clock_ms = book.lockout_end;
    send_seed(fresh_entropy(), clock_ms);
    send_key(right_key(), clock_ms);
    repeat (60) begin
      clock_ms = later(clock_ms, TIME_W'($urandom_range(0, 3000)));
      case ($urandom_range(0, 2))
        0:       send_seed(fresh_entropy(), clock_ms);
        1:       send_key(($urandom_range(0, 1) == 0) ? right_key() : $urandom, clock_ms);
        default: send_noise();
      endcase
    end

    drain_replies();
    // Nothing more may come out of the two-stage pipeline.
    repeat (4) @(posedge clk);

    $display("Checked %0d replies: %0d seeds issued, %0d lockouts started, %0d keys accepted.",
             book.replies_checked, book.seeds_issued, book.lockouts_started,
             book.keys_accepted);
    $display("Register settings applied: %0d; highest failure count reached: %0d.",
             settings_used, book.peak_failures);
    if (book.errors == 0 && book.expected_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
